### hdl/tmg_pkg.sv
`default_nettype none
package tmg_pkg;

  localparam int FRAME_DEPTH = 4096;
  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

  localparam logic [15:0] GAMMA_RESET = 16'd4096;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef struct packed {
    logic start;
    logic raw;
  } pow_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } pow_rsp_t;

  // 2^(2^-j) in Q2.30, entry 0 is 2.0
  typedef logic [16:0][31:0] root_tab_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned x;
    longint unsigned res;
    longint unsigned b;
    x = v;
    res = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t t;
    longint unsigned r;
    r = 64'h8000_0000;
    t[0] = 32'h8000_0000;
    for (int j = 1; j <= 16; j++) begin
      r = isqrt64(r << 30);
      t[j] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage
`default_nettype wire

### hdl/tmg_ram.sv
`default_nettype none
module tmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/tmg_pow.sv
`default_nettype none
module tmg_pow (
  input  logic             clk,
  input  logic             rst,
  input  tmg_pkg::pow_req_t req,
  input  logic [31:0]      opa,
  input  logic [31:0]      opb,
  input  logic [15:0]      gamma,
  output tmg_pkg::pow_rsp_t rsp
);
  import tmg_pkg::*;

  typedef enum logic [5:0] {
    P_IDLE = 6'b000001,
    P_NORM = 6'b000010,
    P_LOG  = 6'b000100,
    P_MUL  = 6'b001000,
    P_EXP  = 6'b010000,
    P_FIN  = 6'b100000
  } pstate_t;

  pstate_t state;
  logic [3:0]  step;
  logic        pass;
  logic        raw;
  logic [31:0] b_r;
  logic [15:0] g_r;
  logic [31:0] w;
  logic [4:0]  sh;
  logic [30:0] m;
  logic [15:0] frac;
  logic signed [22:0] lg;
  logic signed [27:0] y;
  logic [31:0] mexp;
  logic [31:0] value;
  logic        done;

  logic [31:0] w_next;
  logic [4:0]  sh_next;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] q;
  logic [15:0] frac_next;
  logic signed [22:0] logv;
  logic signed [22:0] diff;
  logic signed [39:0] t;
  logic signed [11:0] s;
  logic [11:0] n;
  logic [31:0] shifted;

  // binary leading-one search, one halving per cycle
  always_comb begin
    w_next = w;
    sh_next = sh;
    unique case (step[2:0])
      3'd0: if (w[31:16] == '0) begin w_next = w << 16; sh_next = sh | 5'd16; end
      3'd1: if (w[31:24] == '0) begin w_next = w << 8;  sh_next = sh | 5'd8;  end
      3'd2: if (w[31:28] == '0) begin w_next = w << 4;  sh_next = sh | 5'd4;  end
      3'd3: if (w[31:30] == '0) begin w_next = w << 2;  sh_next = sh | 5'd2;  end
      3'd4: if (!w[31])         begin w_next = w << 1;  sh_next = sh | 5'd1;  end
      default: ;
    endcase
  end

  // one shared multiplier: squaring for log2, root products for exp2
  assign mul_a = (state == P_LOG) ? {1'b0, m} : mexp;
  assign mul_b = (state == P_LOG) ? {1'b0, m} : ROOT_TAB[5'(step) + 5'd1];
  assign prod  = mul_a * mul_b;
  assign q     = prod[61:30];

  assign frac_next = {frac[14:0], q[31]};
  assign logv = $signed({2'b00, ~sh, frac_next});
  assign diff = lg - logv;
  assign t    = lg * $signed({1'b0, g_r});

  assign s = $signed(y[27:16]) - 12'sd14;
  assign n = 12'(-s);

  always_comb begin
    if (s >= 12'sd2) begin
      shifted = '1;
    end else if (s == 12'sd1) begin
      shifted = mexp[31] ? '1 : {mexp[30:0], 1'b0};
    end else if (s == 12'sd0) begin
      shifted = mexp;
    end else if (n >= 12'd31) begin
      shifted = '0;
    end else begin
      shifted = mexp >> n[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (req.start) begin
            raw  <= req.raw;
            b_r  <= opb;
            g_r  <= gamma;
            w    <= opa;
            sh   <= '0;
            step <= '0;
            pass <= 1'b0;
            if (opa == '0) begin
              value <= (gamma == '0) ? ONE_Q16 : '0;
              done  <= 1'b1;
            end else begin
              state <= P_NORM;
            end
          end
        end
        P_NORM: begin
          w    <= w_next;
          sh   <= sh_next;
          step <= step + 4'd1;
          if (step == 4'd4) begin
            m     <= w_next[31:1];
            frac  <= '0;
            step  <= '0;
            state <= P_LOG;
          end
        end
        P_LOG: begin
          m    <= q[31] ? q[31:1] : q[30:0];
          frac <= frac_next;
          step <= step + 4'd1;
          if (step == 4'd15) begin
            step <= '0;
            if (!pass) begin
              lg <= raw ? logv - 23'sd1048576 : logv;
              if (raw) begin
                state <= P_MUL;
              end else begin
                pass  <= 1'b1;
                w     <= b_r;
                sh    <= '0;
                state <= P_NORM;
              end
            end else begin
              lg    <= (diff > 23'sd0) ? 23'sd0 : diff;
              state <= P_MUL;
            end
          end
        end
        P_MUL: begin
          y     <= t[39:12];
          mexp  <= 32'h4000_0000;
          step  <= '0;
          state <= P_EXP;
        end
        P_EXP: begin
          if (y[4'd15 - step]) begin
            mexp <= q;
          end
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= P_FIN;
          end
        end
        P_FIN: begin
          value <= shifted;
          done  <= 1'b1;
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule
`default_nettype wire

### hdl/tonemap_minmax_gamma.sv
// tonemap_minmax_gamma: gamma tone mapping of one HDR frame held in a local store.
//
// Input channel (in_valid / in_stall, fields kind, sample): kind load writes
// sample (Q16.16) into the frame store and updates the running min and max;
// kind read returns the next stored sample, mapped. Loads give no result.
// Output channel (out_valid / out_stall): mapped, last, status per read item.
// Config: cfg_we / cfg_wdata write inv_gamma (Q4.12); write only while idle.
//
// Timing: a load is done in the cycle it is taken. A read item goes RAM read,
// then the pow unit: a leading-one normalize and 16 squarings per log2
// on one shared 32x32 multiplier, one gamma multiply, 16 root products for
// exp2. The pow unit runs one log2 when max equals min, two otherwise; after
// the RAM read, the pow unit, the capture and the hand-off, the result is in
// the output register (a zero operand skips the pow steps, an empty read goes
// straight to the hand-off), and the next item can be taken in the following cycle.
// One item is in work at a time; in_stall is high while it is.
// A finished result sits in the output register, so the next item is taken
// while the receiver stalls; a later result waits until that register frees.
// Reset (rst, synchronous) empties the frame and sets inv_gamma to gamma one;
// the store contents are not cleared, only the count.
`default_nettype none
module tonemap_minmax_gamma (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] mapped,
  output logic        last,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import tmg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CALC  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [15:0]      inv_gamma;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] read_pointer;
  logic [31:0]      running_min;
  logic [31:0]      running_max;
  logic             overflow_flag;
  logic             reading_phase;

  // staged result, waiting for the output register
  logic [31:0] res_mapped;
  logic        res_last;
  logic [1:0]  res_status;

  logic             accept;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]      rd_data;
  logic             out_free;
  logic             raw_mode;
  pow_req_t         pow_req;
  pow_rsp_t         pow_rsp;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // a load after a read-out has begun restarts the frame at entry 0
  assign ram_we    = accept && (kind == KIND_LOAD) &&
                     (reading_phase || stored_count != CNT_W'(FRAME_DEPTH));
  assign ram_waddr = reading_phase ? '0 : stored_count[ADDR_W-1:0];

  tmg_ram #(
    .WIDTH(32),
    .DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(sample),
    .raddr(read_pointer[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  // flat frame: map the raw sample instead of the normalized one
  assign raw_mode      = !(running_max > running_min);
  assign pow_req.start = (state == S_FETCH);
  assign pow_req.raw   = raw_mode;

  tmg_pow u_pow (
    .clk  (clk),
    .rst  (rst),
    .req  (pow_req),
    .opa  (raw_mode ? rd_data : rd_data - running_min),
    .opb  (running_max - running_min),
    .gamma(inv_gamma),
    .rsp  (pow_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      inv_gamma     <= GAMMA_RESET;
      stored_count  <= '0;
      read_pointer  <= '0;
      running_min   <= '1;
      running_max   <= '0;
      overflow_flag <= 1'b0;
      reading_phase <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_gamma <= cfg_wdata;
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_LOAD) begin
              if (reading_phase) begin
                reading_phase <= 1'b0;
                read_pointer  <= '0;
                overflow_flag <= 1'b0;
                stored_count  <= CNT_W'(1);
                running_min   <= sample;
                running_max   <= sample;
              end else if (stored_count == CNT_W'(FRAME_DEPTH)) begin
                overflow_flag <= 1'b1;
              end else begin
                stored_count <= stored_count + CNT_W'(1);
                if (sample < running_min) running_min <= sample;
                if (sample > running_max) running_max <= sample;
              end
            end else if (read_pointer >= stored_count) begin
              res_mapped <= '0;
              res_last   <= 1'b0;
              res_status <= STATUS_EMPTY;
              state      <= S_DONE;
            end else begin
              reading_phase <= 1'b1;
              read_pointer  <= read_pointer + CNT_W'(1);
              res_last      <= (read_pointer + CNT_W'(1) == stored_count);
              res_status    <= overflow_flag ? STATUS_OVF : STATUS_OK;
              state         <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_CALC;
        S_CALC: begin
          if (pow_rsp.done) begin
            res_mapped <= pow_rsp.value;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            mapped    <= res_mapped;
            last      <= res_last;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(FRAME_DEPTH))
    else $error("stored count beyond frame depth");

  a_pointer_bound: assert property (@(posedge clk) disable iff (rst)
    read_pointer <= stored_count)
    else $error("read pointer passed stored count");

  a_minmax: assert property (@(posedge clk) disable iff (rst)
    (stored_count != '0) |-> (running_min <= running_max))
    else $error("running min above running max");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_LOAD && !reading_phase &&
     stored_count == CNT_W'(FRAME_DEPTH)) |=> overflow_flag)
    else $error("load into full store did not flag overflow");

  a_read_start: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_READ && read_pointer < stored_count) |=> state == S_FETCH)
    else $error("read item did not start a fetch");

endmodule
`default_nettype wire

### tb/tonemap_checker.sv
`timescale 1ns / 100ps
module tonemap_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [31:0] sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] mapped,
  input  logic        last,
  input  logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import tmg_pkg::*;

  typedef struct packed {
    logic [31:0] mapped;
    logic        last;
    logic [1:0]  status;
  } tone_res_t;

  logic [31:0] store_mem [FRAME_DEPTH];
  int unsigned cnt, rptr;
  logic [31:0] mn, mx;
  bit          ovf, reading;
  logic [15:0] gam;
  logic [31:0] roots [17];
  tone_res_t   tone_q[$];

  assign pending = tone_q.size();

  function automatic longint unsigned sqrt_u64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint fdiv(longint t, int s);
    if (t >= 0) return t >>> s;
    return -((-t + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function automatic longint log2_fx(longint unsigned v, int fb);
    int p;
    longint unsigned m;
    longint fr;
    p = 63;
    fr = 0;
    while (v[p] == 1'b0) p--;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return (longint'(p) - fb) * 65536 + fr;
  endfunction

  function automatic logic [31:0] exp2_fx(longint lg, logic [15:0] g);
    longint y, k, s;
    longint unsigned m, r;
    logic [15:0] f;
    m = 64'h4000_0000;
    y = fdiv(lg * longint'(g), 12);
    k = fdiv(y, 16);
    f = 16'(y - k * 65536);
    for (int j = 1; j <= 16; j++)
      if (f[16 - j]) m = (m * roots[j]) >> 30;
    s = k - 14;
    if (s >= 2) return 32'hFFFF_FFFF;
    if (s >= 0) begin
      r = m << s;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end
    if (-s >= 31) return 32'd0;
    return 32'(m >> (-s));
  endfunction

  function automatic logic [31:0] tone_of(logic [31:0] x);
    longint lg;
    logic [31:0] d;
    if (mx > mn) begin
      d = x - mn;
      if (d == 0) return (gam == 0) ? ONE_Q16 : 32'd0;
      lg = log2_fx(d, 0) - log2_fx(mx - mn, 0);
      if (lg > 0) lg = 0;
    end else begin
      if (x == 0) return (gam == 0) ? ONE_Q16 : 32'd0;
      lg = log2_fx(x, 16);
    end
    return exp2_fx(lg, gam);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    longint unsigned r;
    fail_count = 0;
    roots[0] = 32'h8000_0000;
    r = 64'h8000_0000;
    for (int j = 1; j <= 16; j++) begin
      r = sqrt_u64(r << 30);
      roots[j] = r[31:0];
    end
  end

  always @(posedge clk) begin
    tone_res_t e;
    if (rst) begin
      cnt = 0; rptr = 0; mn = '1; mx = 0; ovf = 0; reading = 0;
      gam = GAMMA_RESET;
      tone_q.delete();
    end else begin
      if (cfg_we) gam = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (kind == KIND_LOAD) begin
          if (reading) begin
            cnt = 0; rptr = 0; mn = '1; mx = 0; ovf = 0; reading = 0;
          end
          if (cnt >= FRAME_DEPTH) begin
            ovf = 1;
          end else begin
            store_mem[cnt] = sample;
            cnt++;
            if (sample < mn) mn = sample;
            if (sample > mx) mx = sample;
          end
        end else if (rptr >= cnt) begin
          tone_q.push_back('{32'd0, 1'b0, STATUS_EMPTY});
        end else begin
          reading = 1;
          e.mapped = tone_of(store_mem[rptr]);
          rptr++;
          e.last = (rptr == cnt);
          e.status = ovf ? STATUS_OVF : STATUS_OK;
          tone_q.push_back(e);
        end
      end
      if (out_valid && !out_stall) begin
        if (tone_q.size() == 0) begin
          report("unexpected item", mapped, 32'd0);
        end else begin
          e = tone_q.pop_front();
          if (mapped !== e.mapped) report("mapped", mapped, e.mapped);
          if (last !== e.last) report("last", 32'(last), 32'(e.last));
          if (status !== e.status) report("status", 32'(status), 32'(e.status));
        end
      end
    end
  end

endmodule

### tb/tonemap_minmax_gamma_tb.sv
`timescale 1ns / 100ps
module tonemap_minmax_gamma_tb;
  import tmg_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_stall, kind;
  logic [31:0] sample;
  logic        out_valid, out_stall;
  logic [31:0] mapped;
  logic        last;
  logic [1:0]  status;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count, pending;
  int          cycle;

  // Sink behavior: 0 random stalls, 1 never stall, 2 long hold-off
  int          sink_mode;
  bit          in_gaps;  // sender idles at random when set

  tonemap_minmax_gamma dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .mapped(mapped), .last(last), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tonemap_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .mapped(mapped), .last(last), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a read item needs its pow run plus output stalls; about 5000 items
  // (the store-full frame included) fit well below this even if all were reads
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 4000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted long hold-off so the block backs up
  int hold_cnt;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (sink_mode == 2) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 600) sink_mode = 0;
    end else begin
      hold_cnt <= 0;
      out_stall <= (sink_mode == 0) ? ($urandom_range(99) < 10) : 1'b0;
    end
  end

  // Present one item and hold it until accepted; a random gap may precede it
  task automatic send(logic k, logic [31:0] s);
    if (in_gaps) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // latency margin: a load has no result to wait for
    repeat (80) @(posedge clk);
  endtask

  task automatic set_gamma(logic [15:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample(int n);
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(255);
      2: return 32'h0001_0000 + $urandom_range(65535);
      3: return {$urandom_range(3) == 0, 31'($urandom())};
      default: return n[0] ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  function automatic logic [15:0] rand_gamma();
    case ($urandom_range(4))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd4096;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    int sent, fl;
    rst = 1'b1;
    in_valid = 1'b0; kind = KIND_LOAD; sample = 0;
    cfg_we = 1'b0; cfg_wdata = 0;
    sink_mode = 1; in_gaps = 0; cycle = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read from an empty frame, then extremes with default gamma
    send(KIND_READ, 32'hFFFF_FFFF);
    send(KIND_LOAD, 32'd0);
    send(KIND_LOAD, 32'hFFFF_FFFF);
    send(KIND_LOAD, 32'h0001_0000);
    send(KIND_READ, 0);
    send(KIND_READ, 0);
    send(KIND_READ, 0);
    send(KIND_READ, 0);          // all read: nothing left
    // New frame mid read-out, flat frame uses the raw sample
    send(KIND_LOAD, 32'h0004_0000);
    send(KIND_READ, 0);
    send(KIND_LOAD, 32'h0009_0000);
    send(KIND_LOAD, 32'h0009_0000);
    send(KIND_READ, 0);
    drain();
    // Zero exponent, then flat zero frame
    set_gamma(16'd0);
    send(KIND_LOAD, 32'd0);
    send(KIND_LOAD, 32'h1234_5678);
    send(KIND_READ, 0);
    send(KIND_READ, 0);
    send(KIND_LOAD, 32'd0);
    send(KIND_READ, 0);
    drain();
    set_gamma(16'hFFFF);
    send(KIND_LOAD, 32'hFFFF_FFFF);
    send(KIND_READ, 0);
    send(KIND_LOAD, 32'h0000_0001);
    send(KIND_READ, 0);
    drain();

    // Store full: two loads past the depth, then a few read-outs with overflow status
    set_gamma(16'd2048);
    for (int i = 0; i < FRAME_DEPTH + 2; i++) send(KIND_LOAD, $urandom());
    for (int i = 0; i < 6; i++) send(KIND_READ, 0);
    drain();

    // Random frames: mostly load a short frame then read it, with some reads extra or missing
    sink_mode = 0;
    in_gaps = 1;
    sent = 0;
    fl = 0;
    while (sent < 850) begin
      int n;
      fl++;
      if (fl % 8 == 0) begin
        drain();
        set_gamma(rand_gamma());
      end
      if (fl == 20) begin
        sink_mode = 2;         // long hold-off: block fills and stalls input
      end
      if (fl == 30) in_gaps = 0;
      if (fl == 40) in_gaps = 1;
      if (fl == 30) sink_mode = 1;
      if (fl == 40) sink_mode = 0;
      if (fl == 25) drain();   // sender waits until all results are in
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send(KIND_LOAD, rand_sample(i));
        sent++;
      end
      n = n + $urandom_range(0, 2) - 1;
      if ($urandom_range(9) == 0) n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        send(KIND_READ, $urandom());
        sent++;
      end
    end
    drain();
    set_gamma(16'd4096);
    send(KIND_LOAD, 32'h0000_8000);
    send(KIND_READ, 0);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
